### rtl/sstd_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the sample standard deviation block.
// No dependencies.
package sstd_pkg;
    localparam int MAX_SAMPLES_DEF  = 1024;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int STDEV_W          = 24;
    localparam int STATUS_W         = 2;
    localparam int ROOT_IN_W        = 2 * STDEV_W;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FEW     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;
endpackage

### rtl/sample_standard_deviation.sv
`timescale 1ns / 1ps
// Two-pass sample standard deviation with a bit-serial sequencer.
// Depends on sstd_pkg.

// Samples are taken one word per clock while busy is low; each is written
// into an on-chip store (MAX_SAMPLES deep) while a count and sum run along.
// On the word with last set the block raises busy and works the data set:
// a setup step; the mean (Q.16) by restoring division, one quotient bit per
// cycle, then a hand-off step; a second pass over the store, each sample
// going through a fetch step, a difference step, one shift-add step per
// significant bit of its deviation (at most SAMPLE_WIDTH+17) and a closing
// step; a second division by count-ddof; and a 24-step square root (which
// saturates when the quotient exceeds 48 bits) and a step to post the word.
// The result appears for exactly one cycle with done high; there is no
// back-pressure, so it must be captured then. A set whose count does not
// exceed ddof returns from setup with status 1. Samples beyond capacity are
// dropped and flagged with status 2. ddof, reset to 1, is written on the cfg
// port (always ready), only while idle: the user's duty, not enforced here.
module sample_standard_deviation #(
    parameter int MAX_SAMPLES  = sstd_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_WIDTH = sstd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [SAMPLE_WIDTH-1:0]    sample,
    input  logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,
    output logic                              done,
    output logic [sstd_pkg::STDEV_W-1:0]      stdev_q8,
    output logic [sstd_pkg::STATUS_W-1:0]     status
);
    import sstd_pkg::*;

    localparam int CW      = $clog2(MAX_SAMPLES + 1);       // count width
    localparam int AW      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SUMW    = SAMPLE_WIDTH + CW;             // running sum
    localparam int MW      = SAMPLE_WIDTH + 17;             // signed mean Q.16
    localparam int DSW     = SAMPLE_WIDTH + 18;             // signed deviation
    localparam int DW      = SAMPLE_WIDTH + 17;             // |deviation|
    localparam int ACCW    = 2 * DW + CW;                   // sum of squares
    localparam int NUM_RAW = ACCW - 16;
    localparam int NUM_W   = (NUM_RAW > ROOT_IN_W) ? NUM_RAW : ROOT_IN_W;
    localparam int STEPW   = $clog2(NUM_W + 1);
    localparam int RW      = STDEV_W + 3;                   // root remainder

    typedef enum logic [2:0] {
        S_IDLE, S_SETUP, S_DIV_MEAN, S_FETCH, S_DIFF, S_MUL, S_DIV_VAR, S_ROOT
    } state_t;

    state_t                     state_reg;
    logic [CW-1:0]              count_reg;
    logic signed [SUMW-1:0]     sum_reg;
    logic                       dropped_reg;
    logic                       ddof_reg;
    logic                       neg_reg;
    logic signed [MW-1:0]       mean_reg;
    logic [CW-1:0]              idx_reg;
    logic [ACCW-1:0]            acc_reg;
    logic [2*DW-1:0]            mcand_reg;
    logic [DW-1:0]              mplier_reg;
    logic [NUM_W-1:0]           num_reg;     // dividend / quotient / root input
    logic [CW:0]                rem_reg;
    logic [CW-1:0]              den_reg;
    logic [STEPW-1:0]           step_reg;
    logic [RW-1:0]              rrem_reg;
    logic [STDEV_W-1:0]         root_reg;
    logic                       done_reg;
    logic [STDEV_W-1:0]         stdev_reg;
    logic [STATUS_W-1:0]        status_reg;

    logic signed [SAMPLE_WIDTH-1:0] store [MAX_SAMPLES];
    logic signed [SAMPLE_WIDTH-1:0] rd_reg;

    logic              accept;
    logic              room;
    logic [SUMW-1:0]   abs_sum;
    logic [CW:0]       rem_sh;
    logic              div_ge;
    logic [CW:0]       rem_sub;
    logic [RW-1:0]     rrem_sh;
    logic [RW-1:0]     rtrial;
    logic              root_ge;
    logic signed [DSW-1:0] dev;
    logic [DW-1:0]     abs_dev;
    logic [MW-2:0]     q_mag;
    logic [CW-1:0]     m_count;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign room      = (count_reg < CW'(MAX_SAMPLES));
    assign abs_sum   = sum_reg[SUMW-1] ? SUMW'(-sum_reg) : SUMW'(sum_reg);
    assign m_count   = count_reg - CW'(ddof_reg);

    // restoring division step
    assign rem_sh  = {rem_reg[CW-1:0], num_reg[NUM_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, den_reg});
    assign rem_sub = rem_sh - {1'b0, den_reg};

    // square root step, two radicand bits per step
    assign rrem_sh = {rrem_reg[RW-3:0], num_reg[ROOT_IN_W-1 -: 2]};
    assign rtrial  = RW'({root_reg, 2'b01});
    assign root_ge = (rrem_sh >= rtrial);

    // deviation in Q.16, sample sign-extended
    assign dev     = DSW'($signed({rd_reg, 16'b0})) - DSW'(mean_reg);
    assign abs_dev = dev[DSW-1] ? DW'(-dev) : DW'(dev);
    assign q_mag   = num_reg[MW-2:0];

    always_ff @(posedge clk)
    begin
        if (accept && room)
        begin
            store[count_reg[AW-1:0]] <= sample;
        end
        rd_reg <= store[idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            sum_reg     <= '0;
            dropped_reg <= 1'b0;
            ddof_reg    <= 1'b1;
            done_reg    <= 1'b0;
            stdev_reg   <= '0;
            status_reg  <= STATUS_OK;
            neg_reg     <= 1'b0;
            mean_reg    <= '0;
            idx_reg     <= '0;
            acc_reg     <= '0;
            mcand_reg   <= '0;
            mplier_reg  <= '0;
            num_reg     <= '0;
            rem_reg     <= '0;
            den_reg     <= '0;
            step_reg    <= '0;
            rrem_reg    <= '0;
            root_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid)
            begin
                ddof_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (room)
                        begin
                            count_reg <= count_reg + CW'(1);
                            sum_reg   <= sum_reg + SUMW'(sample);
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                        if (last)
                        begin
                            state_reg <= S_SETUP;
                        end
                    end
                end
                S_SETUP:
                begin
                    if (count_reg <= CW'(ddof_reg))
                    begin
                        done_reg    <= 1'b1;
                        stdev_reg   <= '0;
                        status_reg  <= STATUS_FEW;
                        count_reg   <= '0;
                        sum_reg     <= '0;
                        dropped_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        neg_reg   <= sum_reg[SUMW-1];
                        num_reg   <= NUM_W'({abs_sum, 16'b0});
                        den_reg   <= count_reg;
                        rem_reg   <= '0;
                        step_reg  <= STEPW'(NUM_W);
                        state_reg <= S_DIV_MEAN;
                    end
                end
                S_DIV_MEAN:
                begin
                    if (step_reg == '0)
                    begin
                        mean_reg  <= neg_reg ? -MW'({1'b0, q_mag}) : MW'({1'b0, q_mag});
                        acc_reg   <= '0;
                        idx_reg   <= '0;
                        state_reg <= S_FETCH;
                    end
                    else
                    begin
                        rem_reg  <= div_ge ? rem_sub : rem_sh;
                        num_reg  <= {num_reg[NUM_W-2:0], div_ge};
                        step_reg <= step_reg - STEPW'(1);
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_DIFF;   // store read lands in rd_reg
                end
                S_DIFF:
                begin
                    mcand_reg  <= (2*DW)'(abs_dev);
                    mplier_reg <= abs_dev;
                    idx_reg    <= idx_reg + CW'(1);
                    state_reg  <= S_MUL;
                end
                S_MUL:
                begin
                    if (mplier_reg == '0)
                    begin
                        if (idx_reg == count_reg)
                        begin
                            num_reg   <= NUM_W'(acc_reg[ACCW-1:16]);
                            den_reg   <= m_count;
                            rem_reg   <= '0;
                            step_reg  <= STEPW'(NUM_W);
                            state_reg <= S_DIV_VAR;
                        end
                        else
                        begin
                            state_reg <= S_FETCH;
                        end
                    end
                    else
                    begin
                        if (mplier_reg[0])
                        begin
                            acc_reg <= acc_reg + ACCW'(mcand_reg);
                        end
                        mcand_reg  <= {mcand_reg[2*DW-2:0], 1'b0};
                        mplier_reg <= mplier_reg >> 1;
                    end
                end
                S_DIV_VAR:
                begin
                    if (step_reg == '0)
                    begin
                        rrem_reg  <= '0;
                        root_reg  <= '0;
                        step_reg  <= STEPW'(STDEV_W);
                        state_reg <= S_ROOT;
                    end
                    else
                    begin
                        rem_reg  <= div_ge ? rem_sub : rem_sh;
                        num_reg  <= {num_reg[NUM_W-2:0], div_ge};
                        step_reg <= step_reg - STEPW'(1);
                    end
                end
                S_ROOT:
                begin
                    if ((num_reg >> ROOT_IN_W) != '0)
                    begin
                        // quotient beyond 48 bits: root saturates
                        done_reg  <= 1'b1;
                        stdev_reg <= '1;
                    end
                    else if (step_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        stdev_reg <= root_reg;
                    end
                    else
                    begin
                        rrem_reg <= root_ge ? (rrem_sh - rtrial) : rrem_sh;
                        root_reg <= {root_reg[STDEV_W-2:0], root_ge};
                        // radicand shifts within its 48 bits, upper bits stay clear
                        num_reg  <= NUM_W'({num_reg[ROOT_IN_W-3:0], 2'b00});
                        step_reg <= step_reg - STEPW'(1);
                    end
                    if (((num_reg >> ROOT_IN_W) != '0) || (step_reg == '0))
                    begin
                        status_reg  <= dropped_reg ? STATUS_DROPPED : STATUS_OK;
                        count_reg   <= '0;
                        sum_reg     <= '0;
                        dropped_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign stdev_q8 = stdev_reg;
    assign status   = status_reg;
endmodule

### rtl/sstd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for sample_standard_deviation, bound to the top level.
// Depends on sstd_pkg.
module sstd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [sstd_pkg::STDEV_W-1:0]  stdev_q8,
    input logic [sstd_pkg::STATUS_W-1:0] status
);
    import sstd_pkg::*;

    // a result only comes back once the block is idle again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");

    // an accepted word cannot be answered in the very next cycle
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done) else $error("result right after accept");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == STATUS_OK || status == STATUS_FEW ||
                  status == STATUS_DROPPED)) else $error("bad status");

    a_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_FEW) |-> (stdev_q8 == '0))
        else $error("nonzero result on short set");
endmodule

bind sample_standard_deviation sstd_checker u_sstd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .stdev_q8 (stdev_q8),
    .status   (status)
);
